/* rtl/ffa_pkg.sv */
`default_nettype none
package ffa_pkg;
  localparam int MaxChunks = 64;
  localparam int IdxW = $clog2(MaxChunks);
  localparam int CntW = IdxW + 1;
  localparam logic [31:0] HeaderBytes = 32'd4;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_TABLE     = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

  typedef enum logic {
    CFG_HEAP_BASE  = 1'b0,
    CFG_HEAP_LIMIT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic        op;
    logic [23:0] request_bytes;
    logic [31:0] release_pointer;
  } req_t;

  typedef struct packed {
    logic [31:0] result_pointer;
    logic [1:0]  status;
    logic [31:0] used_bytes;
    logic [31:0] free_bytes;
    logic [31:0] alloc_count;
    logic [31:0] release_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_AREAD, S_AIDX, S_ACHK, S_SHIFT_RD, S_SHIFT_WR, S_CARVE,
    S_FREAD, S_FCHK, S_PUSH_RD, S_PUSH_WR, S_DONE
  } state_t;

  // One table-memory write, issued by the sequencer.
  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  idx;
    logic [31:0]      addr;
    logic [23:0]      len;
    logic             busy;
  } tbl_wr_t;
endpackage
`default_nettype wire

/* rtl/ffa_ram.sv */
`default_nettype none
module ffa_ram #(
  parameter int Depth = 64,
  parameter int Width = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/first_fit_free_list_allocator_top.sv */
// Channel  | valid   | stall   | payload
// request  | valid   | stall   | request (req_t)
// result   | rvalid  | rstall  | result  (rsp_t)
// An allocate walks the free list, reading each entry in S_AREAD, S_AIDX and S_ACHK,
// then removes the hit by shifting later entries up, or carves a new chunk on a miss.
// A free scans the chunk table (S_FREAD, S_FCHK), then pushes the chunk onto the list
// head by shifting the list down (S_PUSH_RD, S_PUSH_WR).
// Reset is synchronous; busy bits sit beside each chunk entry and need no clear.
// A result waits while rstall is high; the next request waits until it drains.
`default_nettype none
module first_fit_free_list_allocator_top
  import ffa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        valid,
  output logic             stall,
  input  wire req_t        request,
  output logic             rvalid,
  input  wire logic        rstall,
  output rsp_t             result
);
  logic [31:0] heap_base, heap_limit, heap_top, bytes_in_use;
  logic [31:0] alloc_tally, release_tally;
  logic [CntW-1:0] chunks_made, free_length, pos;
  state_t state, state_next;
  req_t cur;
  logic [IdxW-1:0] found;
  logic [31:0] rptr;
  logic [1:0]  rstat;

  // Memories: chunk address, chunk length with its busy bit, free order.
  tbl_wr_t tw;
  logic [IdxW-1:0] t_raddr, f_raddr, f_waddr;
  logic [31:0] t_addr_q;
  logic [24:0] t_ent_q;
  logic [23:0] t_len_q;
  logic        t_busy_q;
  logic [IdxW-1:0] f_q, f_wdata;
  logic f_we;
  logic alloc_fit, free_hit;

  ffa_ram #(.Depth(MaxChunks), .Width(32)) u_addr (
    .clk, .we(tw.we), .waddr(tw.idx), .wdata(tw.addr), .raddr(t_raddr),
    .rdata(t_addr_q));
  ffa_ram #(.Depth(MaxChunks), .Width(25)) u_len (
    .clk, .we(tw.we), .waddr(tw.idx), .wdata({tw.busy, tw.len}), .raddr(t_raddr),
    .rdata(t_ent_q));
  ffa_ram #(.Depth(MaxChunks), .Width(IdxW)) u_order (
    .clk, .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(f_raddr),
    .rdata(f_q));

  assign t_len_q = t_ent_q[23:0];
  assign t_busy_q = t_ent_q[24];
  assign alloc_fit = t_len_q >= cur.request_bytes;
  assign free_hit = t_busy_q && (t_addr_q + HeaderBytes == cur.release_pointer);

  logic [32:0] new_top;
  assign new_top = {1'b0, heap_top} + {9'd0, cur.request_bytes} + {1'b0, HeaderBytes};

  logic [IdxW-1:0] chunk_sel;  // chunk read in the alloc walk
  assign chunk_sel = f_q;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (valid && !stall) begin
        state_next = (request.op == OP_FREE) ? S_FREAD : S_AREAD;
      end
      S_AREAD: state_next = (pos < free_length) ? S_AIDX : S_CARVE;
      S_AIDX: state_next = S_ACHK;
      S_ACHK: state_next = alloc_fit ? S_SHIFT_RD : S_AREAD;
      S_SHIFT_RD: state_next = (pos < free_length) ? S_SHIFT_WR : S_DONE;
      S_SHIFT_WR: state_next = S_SHIFT_RD;
      S_CARVE: state_next = S_DONE;
      S_FREAD: state_next = (pos < chunks_made) ? S_FCHK : S_DONE;
      S_FCHK: state_next = free_hit ? S_PUSH_RD : S_FREAD;
      S_PUSH_RD: state_next = (pos == '0) ? S_DONE : S_PUSH_WR;
      S_PUSH_WR: state_next = S_PUSH_RD;
      S_DONE: state_next = (!rvalid || !rstall) ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  // The walk reads free_order[pos] in S_AREAD, the chunk entry it names in
  // S_AIDX, and compares the chunk length in S_ACHK.
  always_comb begin
    t_raddr = (state == S_AIDX) ? chunk_sel : pos[IdxW-1:0];
    f_raddr = pos[IdxW-1:0];
    f_we = 1'b0; f_waddr = pos[IdxW-1:0]; f_wdata = f_q;
    tw = '0;
    unique case (state)
      S_ACHK: if (alloc_fit) begin
        tw.we = 1'b1; tw.idx = found; tw.addr = t_addr_q;
        tw.len = t_len_q; tw.busy = 1'b1;
      end
      S_FCHK: if (free_hit) begin
        tw.we = 1'b1; tw.idx = found; tw.addr = t_addr_q;
        tw.len = t_len_q; tw.busy = 1'b0;
      end
      S_SHIFT_RD: f_raddr = pos[IdxW-1:0] + 1'b1;
      S_SHIFT_WR: begin f_we = 1'b1; f_waddr = pos[IdxW-1:0]; end
      S_PUSH_RD:  f_raddr = pos[IdxW-1:0] - 1'b1;
      S_PUSH_WR:  begin f_we = 1'b1; f_waddr = pos[IdxW-1:0]; end
      S_CARVE: begin
        tw.we = (new_top <= {1'b0, heap_limit}) && chunks_made < CntW'(MaxChunks);
        tw.idx = chunks_made[IdxW-1:0]; tw.addr = heap_top;
        tw.len = cur.request_bytes; tw.busy = 1'b1;
      end
      default: ;
    endcase
    if (state == S_PUSH_RD && pos == '0) begin
      f_we = 1'b1; f_waddr = '0; f_wdata = found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; heap_base <= '0; heap_limit <= 32'd65536; heap_top <= '0;
      bytes_in_use <= '0; alloc_tally <= '0; release_tally <= '0;
      chunks_made <= '0; free_length <= '0; rvalid <= 1'b0;
      pos <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == CFG_HEAP_BASE) begin
          heap_base <= cfg_data;
          if (chunks_made == '0) heap_top <= cfg_data;
        end else heap_limit <= cfg_data;
      end
      if (rvalid && !rstall) rvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (valid && !stall) begin
          cur <= request; pos <= '0;
          rptr <= '0; rstat <= ST_OK;
          if (request.op == OP_FREE) release_tally <= release_tally + 1'b1;
          else alloc_tally <= alloc_tally + 1'b1;
        end
        S_AIDX: found <= chunk_sel;
        S_ACHK: begin
          if (alloc_fit) begin
            bytes_in_use <= bytes_in_use + {8'd0, t_len_q};
            rptr <= t_addr_q + HeaderBytes;
            free_length <= free_length - 1'b1;
          end else pos <= pos + 1'b1;
        end
        S_SHIFT_WR: pos <= pos + 1'b1;
        S_CARVE: begin
          if (new_top > {1'b0, heap_limit}) rstat <= ST_EXHAUSTED;
          else if (chunks_made >= CntW'(MaxChunks)) rstat <= ST_TABLE;
          else begin
            chunks_made <= chunks_made + 1'b1;
            heap_top <= new_top[31:0];
            bytes_in_use <= bytes_in_use + {8'd0, cur.request_bytes} + HeaderBytes;
            rptr <= heap_top + HeaderBytes;
          end
        end
        S_FREAD: begin
          found <= pos[IdxW-1:0];
          if (pos >= chunks_made) rstat <= ST_BAD_FREE;
        end
        S_FCHK: begin
          if (free_hit) begin
            bytes_in_use <= bytes_in_use - {8'd0, t_len_q};
            pos <= (free_length == CntW'(MaxChunks)) ? free_length - 1'b1 : free_length;
            if (free_length < CntW'(MaxChunks)) free_length <= free_length + 1'b1;
          end else pos <= pos + 1'b1;
        end
        S_PUSH_WR: pos <= pos - 1'b1;
        S_DONE: if (!rvalid || !rstall) rvalid <= 1'b1;
        default: ;
      endcase
    end
  end

  // Result register is loaded when the sequence leaves S_DONE.
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rvalid || !rstall)) begin
      result.result_pointer <= rptr;
      result.status <= rstat;
      result.used_bytes <= bytes_in_use;
      result.free_bytes <= heap_limit - heap_base - bytes_in_use;
      result.alloc_count <= alloc_tally;
      result.release_count <= release_tally;
    end
  end

  assign stall = (state != S_IDLE) || rvalid;
endmodule
`default_nettype wire

/* rtl/ffa_checker.sv */
`default_nettype none
module ffa_checker
  import ffa_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic valid,
  input wire logic stall,
  input wire logic rvalid,
  input wire logic rstall,
  input wire rsp_t result
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rvalid && rstall |=> rvalid && $stable(result)) else $error("result changed");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    rvalid |-> stall) else $error("request taken while result waits");
  a_ptr: assert property (@(posedge clk) disable iff (rst)
    rvalid && result.status != ST_OK |-> result.result_pointer == '0)
    else $error("pointer on error");
  a_sum: assert property (@(posedge clk) disable iff (rst)
    valid && !stall |=> stall) else $error("no busy after accept");
endmodule
bind first_fit_free_list_allocator_top ffa_checker u_chk (
  .clk, .rst, .valid, .stall, .rvalid, .rstall, .result);
`default_nettype wire

/* tb/first_fit_free_list_allocator_top_test.sv */
`default_nettype none
module first_fit_free_list_allocator_top_test;
  import ffa_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        valid = 1'b0;
  logic        stall;
  req_t        request = '0;
  logic        rvalid;
  logic        rstall = 1'b0;
  rsp_t        result;

  first_fit_free_list_allocator_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .valid(valid), .stall(stall), .request(request),
    .rvalid(rvalid), .rstall(rstall), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the allocator: chunk table, free list, heap top and tallies.
  logic [31:0] base_reg, limit_reg;
  logic [31:0] chunk_addr [MaxChunks];
  logic [23:0] chunk_len [MaxChunks];
  logic        chunk_taken [MaxChunks];
  int          chunks_carved;
  int          free_list [$];
  logic [31:0] top_of_heap, in_use, allocs_seen, releases_seen;

  // Pointers currently held by the stimulus, so frees can target live chunks.
  logic [31:0] live_ptrs [$];
  logic [31:0] dead_ptrs [$];

  req_t pending_requests [$];
  rsp_t expected_results [$];

  int sender_idle_pct, receiver_idle_pct;
  int error_count;
  int accepted_requests, checked_results;
  int idle_cycles;
  bit hold_sender;
  int status_seen [4];
  localparam int WatchdogLimit = 20000;

  // Handshake state captured at the rising edge, so the driver never races the block.
  logic stall_sampled = 1'b1;

  task automatic reset_shadow();
    base_reg = 32'd0;
    limit_reg = 32'd65536;
    for (int i = 0; i < MaxChunks; i++) chunk_taken[i] = 1'b0;
    chunks_carved = 0;
    free_list.delete();
    top_of_heap = 32'd0;
    in_use = '0;
    allocs_seen = '0;
    releases_seen = '0;
  endtask

  function automatic rsp_t predict_allocation(req_t r);
    rsp_t o;
    logic [32:0] new_top;
    bit done;
    int hit;
    int c;
    o = '0;
    done = 0;
    hit = -1;
    if (op_t'(r.op) == OP_ALLOC) begin
      allocs_seen++;
      // First fit walks the free list from its head; no splitting.
      foreach (free_list[i]) begin
        if (hit < 0 && chunk_len[free_list[i]] >= r.request_bytes) hit = i;
      end
      if (hit >= 0) begin
        c = free_list[hit];
        free_list.delete(hit);
        chunk_taken[c] = 1'b1;
        in_use += 32'(chunk_len[c]);
        o.result_pointer = chunk_addr[c] + HeaderBytes;
        o.status = ST_OK;
      end else begin
        new_top = {1'b0, top_of_heap} + 33'(r.request_bytes) + 33'(HeaderBytes);
        if (new_top > {1'b0, limit_reg}) begin
          o.status = ST_EXHAUSTED;
        end else if (chunks_carved >= MaxChunks) begin
          o.status = ST_TABLE;
        end else begin
          chunk_addr[chunks_carved] = top_of_heap;
          chunk_len[chunks_carved] = r.request_bytes;
          chunk_taken[chunks_carved] = 1'b1;
          chunks_carved++;
          o.result_pointer = top_of_heap + HeaderBytes;
          top_of_heap = new_top[31:0];
          in_use += 32'(r.request_bytes) + HeaderBytes;
          o.status = ST_OK;
        end
      end
    end else begin
      releases_seen++;
      o.status = ST_BAD_FREE;
      // The lowest matching busy index is the one released.
      for (int i = 0; i < chunks_carved; i++) begin
        if (!done && chunk_taken[i] && chunk_addr[i] + HeaderBytes == r.release_pointer) begin
          chunk_taken[i] = 1'b0;
          in_use -= 32'(chunk_len[i]);
          free_list.push_front(i);
          o.status = ST_OK;
          done = 1;
        end
      end
    end
    o.used_bytes = in_use;
    o.free_bytes = limit_reg - base_reg - in_use;
    o.alloc_count = allocs_seen;
    o.release_count = releases_seen;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("mismatch on result %0d: %s got %h expected %h", checked_results, what, got, want);
  endtask

  // The driver presents requests at the falling edge and holds them while stalled.
  always @(negedge clk) begin
    if (!rst) begin
      if (valid && !stall_sampled) begin
        if (!hold_sender && pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          request <= pending_requests.pop_front();
          valid <= 1'b1;
        end else begin
          valid <= 1'b0;
        end
      end else if (!valid) begin
        if (!hold_sender && pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          request <= pending_requests.pop_front();
          valid <= 1'b1;
        end
      end
      rstall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  // The monitor predicts at request acceptance and checks at result acceptance.
  always @(posedge clk) begin
    stall_sampled <= rst ? 1'b1 : !(valid && !stall);
    if (!rst) begin
      if ((valid && !stall) || (rvalid && !rstall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (valid && !stall) begin
        expected_results.push_back(predict_allocation(request));
        accepted_requests++;
      end
      if (rvalid && !rstall) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("result arrived with no request outstanding");
        end else begin
          rsp_t e;
          e = expected_results.pop_front();
          status_seen[e.status]++;
          if (result.result_pointer !== e.result_pointer)
            report_mismatch("result_pointer", result.result_pointer, e.result_pointer);
          if (result.status !== e.status)
            report_mismatch("status", 32'(result.status), 32'(e.status));
          if (result.used_bytes !== e.used_bytes)
            report_mismatch("used_bytes", result.used_bytes, e.used_bytes);
          if (result.free_bytes !== e.free_bytes)
            report_mismatch("free_bytes", result.free_bytes, e.free_bytes);
          if (result.alloc_count !== e.alloc_count)
            report_mismatch("alloc_count", result.alloc_count, e.alloc_count);
          if (result.release_count !== e.release_count)
            report_mismatch("release_count", result.release_count, e.release_count);
        end
        checked_results++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog expired with %0d results outstanding", expected_results.size());
        $display("FAIL first_fit_free_list_allocator_top");
        $finish;
      end
    end
  end

  function automatic req_t make_alloc(int unsigned bytes);
    req_t r;
    r = '0;
    r.op = OP_ALLOC;
    r.request_bytes = bytes[23:0];
    r.release_pointer = $urandom();
    return r;
  endfunction

  function automatic req_t make_free(logic [31:0] ptr);
    req_t r;
    r = '0;
    r.op = OP_FREE;
    r.request_bytes = 24'($urandom());
    r.release_pointer = ptr;
    return r;
  endfunction

  // Wait until every queued request is sent and every result has come back.
  task automatic drain();
    while (pending_requests.size() > 0 || valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register writes happen only while the block is idle.
  task automatic write_register(cfg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_HEAP_BASE) begin
      base_reg = value;
      if (chunks_carved == 0) top_of_heap = value;
    end else begin
      limit_reg = value;
    end
  endtask

  // No second reset exists, so a fresh region is only the registers moving;
  // the existing chunks stay and the pointer pools stay valid.
  task automatic rst_shadow_phase(logic [31:0] b, logic [31:0] l);
    write_register(CFG_HEAP_LIMIT, l);
    write_register(CFG_HEAP_BASE, b);
  endtask

  // Random traffic: mostly allocations of small sizes and frees of live pointers,
  // with a few frees of stale or random pointers and occasional huge requests.
  // The sender's copy of live pointers is a guess; the predictor decides.
  task automatic queue_random(int count, int max_bytes);
    for (int n = 0; n < count; n++) begin
      int pick;
      pick = $urandom_range(99);
      if (pick < 50) begin
        int unsigned sz;
        sz = ($urandom_range(19) == 0) ? $urandom() & 24'hFFFFFF : $urandom_range(max_bytes);
        pending_requests.push_back(make_alloc(sz));
      end else if (pick < 88 && live_ptrs.size() > 0) begin
        int k;
        k = $urandom_range(live_ptrs.size() - 1);
        pending_requests.push_back(make_free(live_ptrs[k]));
        dead_ptrs.push_back(live_ptrs[k]);
        live_ptrs.delete(k);
      end else if (pick < 94 && dead_ptrs.size() > 0) begin
        pending_requests.push_back(make_free(dead_ptrs[$urandom_range(dead_ptrs.size() - 1)]));
      end else begin
        pending_requests.push_back(make_free($urandom()));
      end
    end
  endtask

  // Pointer harvesting runs alongside the monitor: every good allocate is recorded.
  always @(posedge clk) begin
    if (!rst && rvalid && !rstall && result.status == ST_OK && result.result_pointer != 0)
      live_ptrs.push_back(result.result_pointer);
  end

  initial begin
    hold_sender = 0;
    sender_idle_pct = 37;
    receiver_idle_pct = 58;
    reset_shadow();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes of size, exhaustion, bad and double frees, reuse.
    write_register(CFG_HEAP_BASE, 32'h0000_1000);
    write_register(CFG_HEAP_LIMIT, 32'h0000_2000);
    pending_requests.push_back(make_alloc(0));
    pending_requests.push_back(make_alloc(24'd100));
    pending_requests.push_back(make_alloc(24'hFF_FFFF));
    pending_requests.push_back(make_free(32'h0000_1004));
    pending_requests.push_back(make_free(32'h0000_1004));
    pending_requests.push_back(make_free(32'hFFFF_FFFF));
    pending_requests.push_back(make_free(32'h0000_0000));
    pending_requests.push_back(make_alloc(0));
    pending_requests.push_back(make_free(32'h0000_100C));
    pending_requests.push_back(make_alloc(24'd50));
    pending_requests.push_back(make_alloc(24'd200));
    pending_requests.push_back(make_alloc(24'd4000));
    pending_requests.push_back(make_alloc(24'd4100));
    drain();
    // Hold the sender off while the block sits idle after draining.
    hold_sender = 1;
    repeat (20) @(posedge clk);
    hold_sender = 0;

    // The base and limit move near the top of the address space; chunks exist, so the heap top stays.
    rst_shadow_phase(32'hFFFF_FF00, 32'hFFFF_FFFF);
    queue_random(300, 40);
    drain();

    sender_idle_pct = 58;
    receiver_idle_pct = 37;
    write_register(CFG_HEAP_LIMIT, 32'h0001_0000);
    queue_random(350, 300);
    drain();

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    // Base moves after chunks exist: the heap top must not follow it.
    write_register(CFG_HEAP_BASE, 32'h0000_0000);
    write_register(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
    queue_random(350, 64);
    drain();

    $display("covered %0d requests: %0d ok, %0d exhausted, %0d table full, %0d bad free",
             accepted_requests, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (error_count == 0) begin
      $display("PASS first_fit_free_list_allocator_top");
    end else begin
      $display("FAIL first_fit_free_list_allocator_top");
    end
    $finish;
  end
endmodule
`default_nettype wire
